### hw/rtl/ricache_pkg.sv
// shared types, codes and constants of the inode cache table
package ricache_pkg;

  // default sizing
  localparam int unsigned SLOTS_DEFAULT = 64;
  localparam int unsigned IPS_DEFAULT = 16;

  // field widths
  localparam int unsigned DEV_W = 16;
  localparam int unsigned INO_W = 12;
  localparam int unsigned REL_W = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REF_W = 8;
  localparam int unsigned SECTOR_W = 17;
  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned IMAP_W = 8;
  localparam int unsigned SMAP_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMAP = 1'b1;
  localparam logic [IMAP_W-1:0] IMAP_RESET = 8'd1;
  localparam logic [SMAP_W-1:0] SMAP_RESET = 16'd1;

  // boot sector and super block come before the inode map
  localparam int unsigned SECTORS_BEFORE_IMAP = 1 + 1;

  // reciprocal division by the inodes-per-sector constant (divisor up to 64)
  localparam int unsigned DIV_SHIFT = INO_W + 6;
  localparam int unsigned RECIP_W = DIV_SHIFT + 1;
  localparam int unsigned PROD_W = INO_W + RECIP_W;
  localparam int unsigned QD_W = INO_W + 7;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // commands
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUT_OK = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd6;

  localparam logic [REF_W-1:0] REF_MAX = 8'd255;

  // request kind after classification
  typedef enum logic [1:0] {
    KIND_GET,
    KIND_PUT,
    KIND_NULL
  } kind_e;

  typedef struct packed {
    logic             command;
    logic [DEV_W-1:0] device;
    logic [INO_W-1:0] inode_number;
    logic [REL_W-1:0] release_slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REL_W-1:0]    slot;
    logic [REF_W-1:0]    ref_count;
    logic [SECTOR_W-1:0] sector_number;
    logic [ENTRY_W-1:0]  entry_in_sector;
  } out_item_t;

  // classified request as it travels through the queue
  typedef struct packed {
    kind_e               kind;
    logic [DEV_W-1:0]    device;
    logic [INO_W-1:0]    inode_number;
    logic [REL_W-1:0]    release_slot;
    logic [SECTOR_W-1:0] sector_number;
    logic [ENTRY_W-1:0]  entry_in_sector;
  } work_t;

  typedef struct packed {
    logic [IMAP_W-1:0] imap_sectors;
    logic [SMAP_W-1:0] smap_sectors;
  } cfg_t;

endpackage

### hw/rtl/refcounted_inode_cache_table_core.sv
// top level of the reference-counted inode cache table
//
// Requests come in on the in channel (in_valid_i / in_stall_o): a get looks
// up a device and inode number and claims the lowest free slot on a miss, a
// put drops one reference of a slot. Every request gives exactly one result
// on the out channel (out_valid_o / out_stall_i), in request order.
// A request enters a front stage that classifies it and computes the disk
// sector and entry, then waits in a two-entry queue. The table engine works
// on one request at a time in two steps: a lookup step for the parallel key
// compare and the count memory read, and a commit step for the count update
// and the result write, which waits while a stalled result is held. This
// compare-then-update loop on the slot counts sets the throughput.
// A stalled result holds in the output register while the front and queue
// keep taking requests until the queue fills, then in_stall_o rises.
// Reset clears all slot in-use bits at once (no clearing pass), empties the
// queue and sets both super block registers to 1. Configuration writes
// (cfg_valid_i / cfg_ready_o) are always taken and belong to idle periods.
module refcounted_inode_cache_table_core #(
  parameter int unsigned SLOTS             = ricache_pkg::SLOTS_DEFAULT,
  parameter int unsigned INODES_PER_SECTOR = ricache_pkg::IPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ricache_pkg::in_item_t               in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ricache_pkg::out_item_t              out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ricache_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ricache_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ricache_pkg::cfg_t  cfg_q;
  logic               push, full, pop, head_valid;
  ricache_pkg::work_t push_data, head;

  // super block registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.imap_sectors <= ricache_pkg::IMAP_RESET;
      cfg_q.smap_sectors <= ricache_pkg::SMAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ricache_pkg::CFG_IMAP: begin
          cfg_q.imap_sectors <= ricache_pkg::IMAP_W'(cfg_data_i);
        end
        ricache_pkg::CFG_SMAP: begin
          cfg_q.smap_sectors <= ricache_pkg::SMAP_W'(cfg_data_i);
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // request front end
  ricache_front #(
    .INODES_PER_SECTOR(INODES_PER_SECTOR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  // decoupling queue
  ricache_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // table engine
  ricache_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hw/rtl/ricache_front.sv
// front end: accepts requests, classifies them and works out the inode location
module ricache_front #(
  parameter int unsigned INODES_PER_SECTOR = ricache_pkg::IPS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ricache_pkg::in_item_t in_data_i,
  input  ricache_pkg::cfg_t    cfg_i,
  output logic                 push_o,
  output ricache_pkg::work_t   push_data_o,
  input  logic                 full_i
);

  localparam int unsigned RECIP =
    ((1 << ricache_pkg::DIV_SHIFT) + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR;

  logic                               s_valid_q, s_valid_d;
  ricache_pkg::kind_e                 s_kind_q;
  ricache_pkg::in_item_t              s_item_q;
  logic [ricache_pkg::INO_W-1:0]      s_quot_q;
  logic                               accept;
  ricache_pkg::kind_e                 kind_in;
  logic [ricache_pkg::INO_W-1:0]      idx_in;
  logic [ricache_pkg::PROD_W-1:0]     prod;
  logic [ricache_pkg::INO_W-1:0]      idx_s;
  logic [ricache_pkg::QD_W-1:0]       qd;
  logic [ricache_pkg::QD_W-1:0]       rem;

  assign in_stall_o = s_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s_valid_q && !full_i;

  // classify the incoming request
  always_comb begin
    if (in_data_i.command == ricache_pkg::CMD_PUT) begin
      kind_in = ricache_pkg::KIND_PUT;
    end else if (in_data_i.inode_number == '0) begin
      kind_in = ricache_pkg::KIND_NULL;
    end else begin
      kind_in = ricache_pkg::KIND_GET;
    end
  end

  // quotient by reciprocal multiply, exact for every 12-bit index
  assign idx_in = in_data_i.inode_number - ricache_pkg::INO_W'(1);
  assign prod   = ricache_pkg::PROD_W'(idx_in) * ricache_pkg::PROD_W'(RECIP);

  // stage valid
  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (push_o) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_kind_q <= kind_in;
      s_item_q <= in_data_i;
      s_quot_q <= ricache_pkg::INO_W'(prod >> ricache_pkg::DIV_SHIFT);
    end
  end

  // remainder and sector from the registered quotient
  assign idx_s = s_item_q.inode_number - ricache_pkg::INO_W'(1);
  assign qd    = ricache_pkg::QD_W'(ricache_pkg::QD_W'(s_quot_q) *
                                    ricache_pkg::QD_W'(INODES_PER_SECTOR));
  assign rem   = ricache_pkg::QD_W'(idx_s) - qd;

  always_comb begin
    push_data_o.kind            = s_kind_q;
    push_data_o.device          = s_item_q.device;
    push_data_o.inode_number    = s_item_q.inode_number;
    push_data_o.release_slot    = s_item_q.release_slot;
    push_data_o.sector_number   = ricache_pkg::SECTOR_W'(ricache_pkg::SECTORS_BEFORE_IMAP) +
                                  ricache_pkg::SECTOR_W'(cfg_i.imap_sectors) +
                                  ricache_pkg::SECTOR_W'(cfg_i.smap_sectors) +
                                  ricache_pkg::SECTOR_W'(s_quot_q);
    push_data_o.entry_in_sector = ricache_pkg::ENTRY_W'(rem);
  end

endmodule

### hw/rtl/ricache_queue.sv
// short request queue between the front end and the table engine
module ricache_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ricache_pkg::work_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output ricache_pkg::work_t head_o
);

  ricache_pkg::work_t                 mem_q [ricache_pkg::QUEUE_DEPTH];
  logic [ricache_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [ricache_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o       = (cnt_q == ricache_pkg::QCNT_W'(ricache_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + ricache_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - ricache_pkg::QCNT_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + ricache_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + ricache_pkg::QPTR_W'(1);
      end
    end
  end

  // entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/ricache_back.sv
// table engine: slot store, parallel lookup, count update and result register
module ricache_back #(
  parameter int unsigned SLOTS = ricache_pkg::SLOTS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  ricache_pkg::work_t     head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ricache_pkg::out_item_t out_data_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  // slot store: keys in flops for the parallel compare, counts in a memory
  logic [ricache_pkg::DEV_W-1:0] dev_q [SLOTS];
  logic [ricache_pkg::INO_W-1:0] ino_q [SLOTS];
  logic [ricache_pkg::REF_W-1:0] refs_mem [SLOTS];
  logic [SLOTS-1:0]              used_q;

  logic                          state_q, state_d;
  logic [SLOTS-1:0]              match_vec;
  logic                          hit_any, free_any, rel_in;
  logic [SW-1:0]                 hit_idx, free_idx, rel_idx, rd_addr;

  ricache_pkg::work_t            work_q;
  logic                          hit_q, free_q, put_ok_q;
  logic [SW-1:0]                 hit_idx_q, free_idx_q, rel_idx_q;
  logic [ricache_pkg::REF_W-1:0] ref_rd_q;

  logic                          do_commit;
  logic                          ref_we, used_set, used_clr, claim;
  logic [SW-1:0]                 wr_idx;
  logic [ricache_pkg::REF_W-1:0] ref_wd;
  ricache_pkg::out_item_t        res;

  logic                          out_valid_q;
  ricache_pkg::out_item_t        out_data_q;

  assign pop_o     = (state_q == S_IDLE) && head_valid_i;
  assign do_commit = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);

  // parallel key compare and first-slot search on the queue head
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = used_q[i] && (dev_q[i] == head_i.device) &&
                     (ino_q[i] == head_i.inode_number);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = SW'(i);
      end
      if (!used_q[i]) begin
        free_idx = SW'(i);
      end
    end
    hit_any  = |match_vec;
    free_any = ~&used_q;
    rel_idx  = SW'(head_i.release_slot);
    rel_in   = (32'(head_i.release_slot) < SLOTS);
    rd_addr  = (head_i.kind == ricache_pkg::KIND_PUT) ? rel_idx : hit_idx;
  end

  // lookup results held for the commit state
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q     <= head_i;
      hit_q      <= hit_any;
      free_q     <= free_any;
      hit_idx_q  <= hit_idx;
      free_idx_q <= free_idx;
      rel_idx_q  <= rel_idx;
      put_ok_q   <= rel_in && used_q[rel_idx];
    end
  end

  // count memory: read at lookup, written at commit
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ref_rd_q <= refs_mem[rd_addr];
    end
    if (ref_we) begin
      refs_mem[wr_idx] <= ref_wd;
    end
  end

  // commit decision and result
  always_comb begin
    ref_we   = 1'b0;
    used_set = 1'b0;
    used_clr = 1'b0;
    claim    = 1'b0;
    wr_idx   = free_idx_q;
    ref_wd   = '0;
    res      = '0;
    case (work_q.kind)
      ricache_pkg::KIND_PUT: begin
        res.slot = work_q.release_slot;
        wr_idx   = rel_idx_q;
        if (put_ok_q) begin
          ref_wd        = ref_rd_q - ricache_pkg::REF_W'(1);
          ref_we        = do_commit;
          used_clr      = do_commit && (ref_wd == '0);
          res.status    = ricache_pkg::ST_PUT_OK;
          res.ref_count = ref_wd;
        end else begin
          res.status = ricache_pkg::ST_UNDERFLOW;
        end
      end
      ricache_pkg::KIND_GET: begin
        if (hit_q) begin
          wr_idx   = hit_idx_q;
          res.slot = ricache_pkg::REL_W'(hit_idx_q);
          if (ref_rd_q == ricache_pkg::REF_MAX) begin
            res.status    = ricache_pkg::ST_SATURATED;
            res.ref_count = ricache_pkg::REF_MAX;
          end else begin
            ref_wd        = ref_rd_q + ricache_pkg::REF_W'(1);
            ref_we        = do_commit;
            res.status    = ricache_pkg::ST_HIT;
            res.ref_count = ref_wd;
          end
        end else if (free_q) begin
          ref_wd              = ricache_pkg::REF_W'(1);
          ref_we              = do_commit;
          used_set            = do_commit;
          claim               = do_commit;
          res.status          = ricache_pkg::ST_MISS;
          res.slot            = ricache_pkg::REL_W'(free_idx_q);
          res.ref_count       = ref_wd;
          res.sector_number   = work_q.sector_number;
          res.entry_in_sector = work_q.entry_in_sector;
        end else begin
          res.status = ricache_pkg::ST_FULL;
        end
      end
      default: begin
        res.status = ricache_pkg::ST_NULL;
      end
    endcase
  end

  // keys of a claimed slot
  always_ff @(posedge clk_i) begin
    if (claim) begin
      dev_q[free_idx_q] <= work_q.device;
      ino_q[free_idx_q] <= work_q.inode_number;
    end
  end

  // sequencer, in-use bits and result valid
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (do_commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= do_commit || (out_valid_q && out_stall_i);
      if (used_set) begin
        used_q[wr_idx] <= 1'b1;
      end
      if (used_clr) begin
        used_q[wr_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (do_commit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### verif/refcounted_inode_cache_table_core_test.sv
// self-checking testbench of the reference-counted inode cache table core
`timescale 1ns / 1ps

module refcounted_inode_cache_table_core_test;
  import ricache_pkg::*;

  localparam int unsigned NUM_SLOTS = 64;
  localparam int unsigned IPS = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;

  // result side
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // configuration side
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the table and the super block layout
  logic [DEV_W-1:0] shadow_device [NUM_SLOTS];
  logic [INO_W-1:0] shadow_inode [NUM_SLOTS];
  logic [REF_W-1:0] shadow_refs [NUM_SLOTS];
  logic [IMAP_W-1:0] shadow_imap = IMAP_RESET;
  logic [SMAP_W-1:0] shadow_smap = SMAP_RESET;

  out_item_t pending_responses[$];
  int unsigned error_count = 0;
  int unsigned result_stall_left = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  refcounted_inode_cache_table_core #(
    .SLOTS(NUM_SLOTS),
    .INODES_PER_SECTOR(IPS)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // table behavior for one request, updates the shadow table
  function automatic out_item_t table_response(input in_item_t req);
    out_item_t res;
    int free_idx;
    int unsigned idx;
    int unsigned sum;
    res = '0;
    free_idx = -1;
    if (req.command == CMD_PUT) begin
      res.slot = req.release_slot;
      if (shadow_refs[req.release_slot] == '0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        shadow_refs[req.release_slot] = shadow_refs[req.release_slot] - 1'b1;
        res.status = ST_PUT_OK;
        res.ref_count = shadow_refs[req.release_slot];
      end
      return res;
    end
    if (req.inode_number == '0) begin
      res.status = ST_NULL;
      return res;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (shadow_refs[i] != '0) begin
        if (shadow_device[i] == req.device && shadow_inode[i] == req.inode_number) begin
          res.slot = REL_W'(i);
          if (shadow_refs[i] >= REF_MAX) begin
            res.status = ST_SATURATED;
            res.ref_count = REF_MAX;
          end else begin
            shadow_refs[i] = shadow_refs[i] + 1'b1;
            res.status = ST_HIT;
            res.ref_count = shadow_refs[i];
          end
          return res;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) begin
      res.status = ST_FULL;
      return res;
    end
    // claim the lowest free slot and locate the inode on disk
    shadow_device[free_idx] = req.device;
    shadow_inode[free_idx] = req.inode_number;
    shadow_refs[free_idx] = 8'd1;
    idx = req.inode_number;
    idx = idx - 1;
    sum = SECTORS_BEFORE_IMAP + shadow_imap + shadow_smap + idx / IPS;
    res.status = ST_MISS;
    res.slot = REL_W'(free_idx);
    res.ref_count = 8'd1;
    res.sector_number = SECTOR_W'(sum);
    res.entry_in_sector = ENTRY_W'(idx % IPS);
    return res;
  endfunction

  function automatic int free_slot_count();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (shadow_refs[i] == '0) n++;
    end
    return n;
  endfunction

  // get request, unused fields filled with noise
  function automatic in_item_t get_req(input logic [DEV_W-1:0] dev,
                                       input logic [INO_W-1:0] ino);
    in_item_t req;
    req.command = CMD_GET;
    req.device = dev;
    req.inode_number = ino;
    req.release_slot = REL_W'($urandom);
    return req;
  endfunction

  function automatic in_item_t put_req(input logic [REL_W-1:0] slot);
    in_item_t req;
    req.command = CMD_PUT;
    req.device = DEV_W'($urandom);
    req.inode_number = INO_W'($urandom);
    req.release_slot = slot;
    return req;
  endfunction

  // send one request, predict its result once accepted
  task automatic send_request(input in_item_t req, output out_item_t predicted);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = ~in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk_i); while (in_stall);
    predicted = table_response(req);
    pending_responses.push_back(predicted);
  endtask

  task automatic send(input in_item_t req);
    out_item_t unused;
    send_request(req, unused);
  endtask

  // stop requests and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  // rewrite both super block registers while the table is idle
  task automatic write_super_block(input logic [IMAP_W-1:0] imap,
                                   input logic [SMAP_W-1:0] smap);
    logic [CFG_DATA_W-1:0] imap_word;
    drain();
    // upper bits of the inode map write are ignored
    imap_word = {8'($urandom), imap};
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IMAP;
    cfg_data <= imap_word;
    do @(posedge clk_i); while (!cfg_ready);
    shadow_imap = imap_word[IMAP_W-1:0];
    cfg_index <= CFG_SMAP;
    cfg_data <= smap;
    do @(posedge clk_i); while (!cfg_ready);
    shadow_smap = smap;
    cfg_valid <= 1'b0;
  endtask

  // null inodes, field extremes, claims, hits, puts and reuse
  task automatic test_directed_cases();
    send(get_req(16'h0000, 12'h000));
    send(get_req(16'hFFFF, 12'h000));
    send(get_req(16'h0000, 12'h001));
    send(get_req(16'hFFFF, 12'hFFF));
    send(get_req(16'h0000, 12'h001));
    send(get_req(16'h0001, 12'h001));
    send(get_req(16'h0000, 12'h002));
    send(get_req(16'h0000, 12'd16));
    send(get_req(16'h0000, 12'd17));
    send(put_req(6'd0));
    send(put_req(6'd0));
    send(put_req(6'd0));
    send(get_req(16'h0000, 12'h001));
    send(put_req(6'd63));
    send(put_req(6'd2));
    send(get_req(16'hFFFF, 12'hFFF));
    send(get_req(16'h0001, 12'h001));
    send(put_req(6'd4));
    send(get_req(16'h5555, 12'hAAA));
    send(get_req(16'hAAAA, 12'h555));
  endtask

  // drive one key's count to the top and beyond
  task automatic test_count_saturation();
    logic [DEV_W-1:0] dev;
    logic [INO_W-1:0] ino;
    out_item_t res;
    dev = DEV_W'($urandom);
    ino = INO_W'($urandom_range(1, 4095));
    repeat (257) send_request(get_req(dev, ino), res);
    // one release below the top, then back up and over
    send(put_req(res.slot));
    send(get_req(dev, ino));
    send(get_req(dev, ino));
  endtask

  // fill every slot, then hit, miss and release on a full table
  task automatic test_full_table();
    out_item_t res;
    logic [REL_W-1:0] claimed[$];
    int guard;
    guard = 0;
    while (free_slot_count() != 0 && guard < 200) begin
      send_request(get_req(DEV_W'($urandom), INO_W'($urandom_range(1, 4095))), res);
      if (res.status == ST_MISS) claimed.push_back(res.slot);
      guard++;
    end
    send(get_req(DEV_W'($urandom), INO_W'($urandom_range(1, 4095))));
    send(get_req(DEV_W'($urandom), INO_W'($urandom_range(1, 4095))));
    send(get_req(shadow_device[NUM_SLOTS-1], shadow_inode[NUM_SLOTS-1]));
    send(get_req(DEV_W'($urandom), '0));
    if (claimed.size() != 0) begin
      send(put_req(claimed[0]));
      send(get_req(DEV_W'($urandom), INO_W'($urandom_range(1, 4095))));
    end
    // give back what this test took
    foreach (claimed[i]) begin
      while (shadow_refs[claimed[i]] != '0) send(put_req(claimed[i]));
    end
  endtask

  // mixed traffic on a key pool under one super block layout
  task automatic random_traffic(input int n_items);
    logic [DEV_W-1:0] pool_dev [128];
    logic [INO_W-1:0] pool_ino [128];
    int pool_size;
    int sel;
    int k;
    int busy[$];
    in_item_t req;
    pool_size = $urandom_range(4, 100);
    for (int i = 0; i < pool_size; i++) begin
      pool_dev[i] = DEV_W'($urandom);
      pool_ino[i] = INO_W'($urandom_range(1, 4095));
    end
    repeat (n_items) begin
      sel = $urandom_range(0, 99);
      busy.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (shadow_refs[i] != '0) busy.push_back(i);
      end
      if (sel < 5) begin
        req = get_req(DEV_W'($urandom), '0);
      end else if (sel < 55) begin
        k = $urandom_range(0, pool_size - 1);
        req = get_req(pool_dev[k], pool_ino[k]);
      end else if (sel < 60) begin
        req = get_req(DEV_W'($urandom), INO_W'($urandom));
      end else if (sel < 92 && busy.size() != 0) begin
        req = put_req(REL_W'(busy[$urandom_range(0, busy.size() - 1)]));
      end else begin
        req = put_req(REL_W'($urandom));
      end
      send(req);
    end
  endtask

  // random traffic under several layouts, extremes included
  task automatic test_super_block_layouts();
    random_traffic(110);
    write_super_block(8'd0, 16'd0);
    random_traffic(110);
    write_super_block(8'd255, 16'd65535);
    random_traffic(110);
    write_super_block(IMAP_W'($urandom), SMAP_W'($urandom));
    random_traffic(110);
    write_super_block(8'd255, 16'd0);
    random_traffic(110);
    write_super_block(8'd0, 16'd65535);
    random_traffic(110);
  endtask

  // compare one result with the oldest expectation
  task automatic check_response(input out_item_t got);
    out_item_t want;
    if (pending_responses.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected result: status %0d slot %0d refs %0d sector %0d entry %0d",
                 got.status, got.slot, got.ref_count, got.sector_number,
                 got.entry_in_sector);
      return;
    end
    want = pending_responses.pop_front();
    if (got.status !== want.status || got.slot !== want.slot ||
        got.ref_count !== want.ref_count || got.sector_number !== want.sector_number ||
        got.entry_in_sector !== want.entry_in_sector) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch: expected status %0d slot %0d refs %0d sector %0d entry %0d, %s",
                 want.status, want.slot, want.ref_count, want.sector_number,
                 want.entry_in_sector,
                 $sformatf("got status %0d slot %0d refs %0d sector %0d entry %0d",
                           got.status, got.slot, got.ref_count, got.sector_number,
                           got.entry_in_sector));
    end
  endtask

  // result side: take results and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      result_stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_response(out_data);
        if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
        result_stall_left = out_calm ? 0 : $urandom_range(0, 5);
      end
      if (result_stall_left > 0) begin
        result_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // shadow table starts cleared
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_device[i] = '0;
      shadow_inode[i] = '0;
      shadow_refs[i] = '0;
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_count_saturation();
    test_full_table();
    test_super_block_layouts();
    drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && pending_responses.size() == 0) begin
      $display("refcounted_inode_cache_table_core verification clean");
    end else begin
      $display("refcounted_inode_cache_table_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("refcounted_inode_cache_table_core verification failed");
    $finish;
  end

endmodule
